// ----- src/mbrd_pkg.sv -----
// Shared types, codes and helper functions for the Modbus RTU response deframer.
`default_nettype none

package mbrd_pkg;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_BAD_LEN  = 3'd1,
    STATUS_BAD_ADDR = 3'd2,
    STATUS_BAD_CRC  = 3'd3,
    STATUS_ABORTED  = 3'd4
  } status_e;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  FcExcBit = 8'h80;
  localparam int unsigned LenW     = 9;

  // Modbus function codes known to the length rules.
  localparam logic [7:0] FcReadCoils      = 8'd1;
  localparam logic [7:0] FcReadDiscrete   = 8'd2;
  localparam logic [7:0] FcReadHolding    = 8'd3;
  localparam logic [7:0] FcReadInput      = 8'd4;
  localparam logic [7:0] FcWriteCoil      = 8'd5;
  localparam logic [7:0] FcWriteReg       = 8'd6;
  localparam logic [7:0] FcReadExcStatus  = 8'd7;
  localparam logic [7:0] FcDiagnostics    = 8'd8;
  localparam logic [7:0] FcCommEventCtr   = 8'd11;
  localparam logic [7:0] FcCommEventLog   = 8'd12;
  localparam logic [7:0] FcWriteCoils     = 8'd15;
  localparam logic [7:0] FcWriteRegs      = 8'd16;
  localparam logic [7:0] FcReportServerId = 8'd17;
  localparam logic [7:0] FcReadFileRec    = 8'd20;
  localparam logic [7:0] FcWriteFileRec   = 8'd21;
  localparam logic [7:0] FcMaskWrite      = 8'd22;
  localparam logic [7:0] FcReadWriteRegs  = 8'd23;
  localparam logic [7:0] FcFifo           = 8'd24;

  // One result item as it leaves the frame logic.
  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       pdu_byte_valid;
    logic       frame_done;
    status_e    frame_status;
    logic [7:0] pdu_length;
  } result_t;

  // Modbus CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // PDU length from function code and the byte after it; zero means unsupported.
  function automatic logic [LenW-1:0] pdu_len_of(input logic [7:0] fc, input logic [7:0] nxt);
    logic [LenW-1:0] len;
    len = '0;
    if ((fc & FcExcBit) != 8'h00) begin
      len = LenW'(2);
    end else begin
      case (fc) inside
        FcReadCoils, FcReadDiscrete, FcReadHolding, FcReadInput, FcCommEventLog,
        FcReportServerId, FcReadFileRec, FcWriteFileRec, FcReadWriteRegs:
          len = LenW'(2) + {1'b0, nxt};
        FcWriteCoil, FcWriteReg, FcDiagnostics, FcCommEventCtr, FcWriteCoils,
        FcWriteRegs:
          len = LenW'(5);
        FcReadExcStatus:
          len = LenW'(2);
        FcMaskWrite:
          len = LenW'(7);
        default:
          len = '0;
      endcase
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- src/mbrd_frame_ctl.sv -----
// Frame state and next-result logic of the Modbus RTU response deframer.
`default_nettype none

module mbrd_frame_ctl #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                restart_i,
  input  logic [7:0]          exp_addr_i,
  output mbrd_pkg::result_t   result_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [16:0] LenLimit = 17'(MAX_FRAME_BYTES - 3);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] total_q, total_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      fc_q, fc_d;
  logic            addr_ok_q, addr_ok_d;
  logic [7:0]      crc_lo_q, crc_lo_d;

  logic [15:0]     crc_next;
  logic [mbrd_pkg::LenW-1:0] tab_len;
  logic [16:0]     fifo_len;
  logic [PosW:0]   pos_p3, pos_p2;
  logic [15:0]     rx_crc;
  logic [PosW-1:0] fin_len;
  logic            clear;

  assign crc_next = mbrd_pkg::crc16_byte(crc_q, rx_byte_i);
  assign tab_len  = mbrd_pkg::pdu_len_of(fc_q, rx_byte_i);
  assign fifo_len = 17'd3 + {1'b0, crc_lo_q, rx_byte_i};
  assign pos_p3   = {1'b0, pos_q} + (PosW+1)'(3);
  assign pos_p2   = {1'b0, pos_q} + (PosW+1)'(2);
  assign rx_crc   = {rx_byte_i, crc_lo_q};
  assign fin_len  = total_q - PosW'(3);

  always_comb begin
    pos_d     = pos_q;
    total_d   = total_q;
    crc_d     = crc_q;
    fc_d      = fc_q;
    addr_ok_d = addr_ok_q;
    crc_lo_d  = crc_lo_q;
    clear     = 1'b0;
    result_o  = '{pdu_byte: 8'h00, pdu_byte_valid: 1'b0, frame_done: 1'b0,
                  frame_status: mbrd_pkg::STATUS_OK, pdu_length: 8'h00};

    if (restart_i) begin
      clear = 1'b1;
      result_o.frame_done   = 1'b1;
      result_o.frame_status = mbrd_pkg::STATUS_ABORTED;
    end else if (pos_q == '0) begin
      addr_ok_d = (rx_byte_i == exp_addr_i);
      crc_d     = crc_next;
      pos_d     = PosW'(1);
    end else if (pos_q == PosW'(1)) begin
      fc_d  = rx_byte_i;
      crc_d = crc_next;
      pos_d = PosW'(2);
      result_o.pdu_byte       = rx_byte_i;
      result_o.pdu_byte_valid = 1'b1;
    end else if (pos_q == PosW'(2)) begin
      if (fc_q == mbrd_pkg::FcFifo) begin
        // hold the count's high byte until the low byte arrives
        crc_lo_d = rx_byte_i;
        total_d  = '0;
        crc_d    = crc_next;
        pos_d    = PosW'(3);
        result_o.pdu_byte       = rx_byte_i;
        result_o.pdu_byte_valid = 1'b1;
      end else if (tab_len == '0 || 17'(tab_len) > LenLimit) begin
        clear = 1'b1;
        result_o.frame_done   = 1'b1;
        result_o.frame_status = mbrd_pkg::STATUS_BAD_LEN;
      end else begin
        total_d = PosW'(tab_len) + PosW'(3);
        crc_d   = crc_next;
        pos_d   = PosW'(3);
        result_o.pdu_byte       = rx_byte_i;
        result_o.pdu_byte_valid = 1'b1;
      end
    end else if (total_q == '0) begin
      if (fifo_len > LenLimit) begin
        clear = 1'b1;
        result_o.frame_done   = 1'b1;
        result_o.frame_status = mbrd_pkg::STATUS_BAD_LEN;
      end else begin
        total_d  = PosW'(fifo_len) + PosW'(3);
        crc_lo_d = 8'h00;
        crc_d    = crc_next;
        pos_d    = PosW'(4);
        result_o.pdu_byte       = rx_byte_i;
        result_o.pdu_byte_valid = 1'b1;
      end
    end else if (pos_p3 <= {1'b0, total_q}) begin
      crc_d = crc_next;
      pos_d = pos_q + PosW'(1);
      result_o.pdu_byte       = rx_byte_i;
      result_o.pdu_byte_valid = 1'b1;
    end else if (pos_p2 == {1'b0, total_q}) begin
      crc_lo_d = rx_byte_i;
      pos_d    = pos_q + PosW'(1);
    end else begin
      clear = 1'b1;
      result_o.frame_done = 1'b1;
      result_o.pdu_length = 8'(fin_len);
      if (!addr_ok_q) begin
        result_o.frame_status = mbrd_pkg::STATUS_BAD_ADDR;
      end else if (rx_crc != crc_q) begin
        result_o.frame_status = mbrd_pkg::STATUS_BAD_CRC;
      end else begin
        result_o.frame_status = mbrd_pkg::STATUS_OK;
      end
    end

    if (clear) begin
      pos_d     = '0;
      total_d   = '0;
      crc_d     = mbrd_pkg::CrcInit;
      fc_d      = 8'h00;
      addr_ok_d = 1'b0;
      crc_lo_d  = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      total_q   <= '0;
      crc_q     <= mbrd_pkg::CrcInit;
      fc_q      <= 8'h00;
      addr_ok_q <= 1'b0;
      crc_lo_q  <= 8'h00;
    end else if (step_i) begin
      pos_q     <= pos_d;
      total_q   <= total_d;
      crc_q     <= crc_d;
      fc_q      <= fc_d;
      addr_ok_q <= addr_ok_d;
      crc_lo_q  <= crc_lo_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/modbus_rtu_response_deframer_unit.sv -----
// Top level of the Modbus RTU response deframer: request registers and config.
//
// Usage: feed one received frame byte per input request (rx_byte_i) with
// restart_i low, or a request with restart_i high when the line timed out.
// Every input request yields exactly one output request. PDU bytes come out
// with pdu_byte_valid_o as they arrive; the request that ends the frame has
// frame_done_o set, frame_status_o (ok, bad length/function, wrong address,
// CRC mismatch, aborted) and pdu_length_o.
// The server address to match is written through cfg_we_i / cfg_wdata_i; write
// it only while no request is in flight (the block does not enforce this).
// The result passes through the input register, then the result register.
// Throughput: one request per cycle while out_ready_i is high; the byte-wide
// CRC-16 update is the longest path between the two registers.
// Reset: frame state returns to idle, the CRC to 0xFFFF, the address to 1,
// and both request registers are emptied.
// Stall: when out_ready_i is low the result holds; the input register takes
// one more request, then in_ready_o drops until the result drains.
`default_nettype none

module modbus_rtu_response_deframer_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pdu_byte_o,
  output logic       pdu_byte_valid_o,
  output logic       frame_done_o,
  output logic [2:0] frame_status_o,
  output logic [7:0] pdu_length_o
);

  logic [7:0]        addr_q;
  logic              in_vld_q;
  logic [7:0]        byte_q;
  logic              restart_q;
  logic              out_vld_q;
  mbrd_pkg::result_t res_q;
  mbrd_pkg::result_t res_d;
  logic              out_free;
  logic              step;

  // advance the result register when it is empty or being drained
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  // configuration register: expected server address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 8'd1;
    end else if (cfg_we_i) begin
      addr_q <= cfg_wdata_i;
    end
  end

  // input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q    <= rx_byte_i;
      restart_q <= restart_i;
    end
  end

  mbrd_frame_ctl #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame_ctl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (byte_q),
    .restart_i (restart_q),
    .exp_addr_i(addr_q),
    .result_o  (res_d)
  );

  // result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign pdu_byte_o       = res_q.pdu_byte;
  assign pdu_byte_valid_o = res_q.pdu_byte_valid;
  assign frame_done_o     = res_q.frame_done;
  assign frame_status_o   = res_q.frame_status;
  assign pdu_length_o     = res_q.pdu_length;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Modbus RTU response deframer unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MaxFrameBytes   = 256;
  localparam logic [7:0]  ResetServerAddr = 8'd1;

  // MEI is not supported by the block; used only as stimulus.
  localparam logic [7:0] FcMei = 8'd43;

  localparam logic [7:0] CountedCodes[9] = '{
    mbrd_pkg::FcReadCoils, mbrd_pkg::FcReadDiscrete, mbrd_pkg::FcReadHolding,
    mbrd_pkg::FcReadInput, mbrd_pkg::FcCommEventLog, mbrd_pkg::FcReportServerId,
    mbrd_pkg::FcReadFileRec, mbrd_pkg::FcWriteFileRec, mbrd_pkg::FcReadWriteRegs};
  localparam logic [7:0] FixedCodes[6] = '{
    mbrd_pkg::FcWriteCoil, mbrd_pkg::FcWriteReg, mbrd_pkg::FcDiagnostics,
    mbrd_pkg::FcCommEventCtr, mbrd_pkg::FcWriteCoils, mbrd_pkg::FcWriteRegs};

  // Kinds of rows in the directed table; CRC rows take their byte from the predictor.
  typedef enum logic [1:0] {ROW_DATA, ROW_RESTART, ROW_CRC_LO, ROW_CRC_HI} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [7:0]        data;
    bit                typed;
    mbrd_pkg::result_t want;
  } stim_row_t;

  // DUT signals; every input holds a known value from time zero.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       restart_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] pdu_byte_o;
  logic       pdu_byte_valid_o;
  logic       frame_done_o;
  logic [2:0] frame_status_o;
  logic [7:0] pdu_length_o;

  // Predictor copy of the register and the frame state.
  logic [7:0] server_addr_q;
  logic [8:0] pos_q;
  logic [8:0] total_q;
  logic [15:0] crc_q;
  logic [7:0] fc_q;
  logic       addr_ok_q;
  logic [7:0] crc_lo_q;
  bit         frame_over_q;

  // Responses still owed by the block, oldest first.
  mbrd_pkg::result_t frame_result_q[$];

  int  err_cnt    = 0;
  int  rsp_cnt    = 0;
  int  req_cnt    = 0;
  bit  quiet_q    = 1'b0;
  int  hold_left  = 0;
  bit  hold_taken = 1'b0;

  modbus_rtu_response_deframer_unit #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pdu_byte_o      (pdu_byte_o),
    .pdu_byte_valid_o(pdu_byte_valid_o),
    .frame_done_o    (frame_done_o),
    .frame_status_o  (frame_status_o),
    .pdu_length_o    (pdu_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Modbus CRC-16: reflected, polynomial 0xA001, one byte at a time, LSB first.
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  // PDU length implied by the function code and the byte after it; 0 flags an
  // unsupported code. The read FIFO queue code is handled by the caller.
  function automatic int unsigned pdu_len_lookup(input logic [7:0] fc, input logic [7:0] nxt);
    if ((fc & mbrd_pkg::FcExcBit) != 8'h00) begin
      return 2;
    end
    case (fc)
      mbrd_pkg::FcReadCoils, mbrd_pkg::FcReadDiscrete, mbrd_pkg::FcReadHolding,
      mbrd_pkg::FcReadInput, mbrd_pkg::FcCommEventLog, mbrd_pkg::FcReportServerId,
      mbrd_pkg::FcReadFileRec, mbrd_pkg::FcWriteFileRec,
      mbrd_pkg::FcReadWriteRegs: return 2 + nxt;
      mbrd_pkg::FcWriteCoil, mbrd_pkg::FcWriteReg, mbrd_pkg::FcDiagnostics,
      mbrd_pkg::FcCommEventCtr, mbrd_pkg::FcWriteCoils,
      mbrd_pkg::FcWriteRegs: return 5;
      mbrd_pkg::FcReadExcStatus: return 2;
      mbrd_pkg::FcMaskWrite: return 7;
      default: return 0;
    endcase
  endfunction

  function automatic stim_row_t prow(input row_kind_e k, input logic [7:0] d);
    stim_row_t s;
    s.kind  = k;
    s.data  = d;
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  function automatic stim_row_t trow(input row_kind_e k, input logic [7:0] d,
                                     input logic [7:0] pb, input logic pv, input logic dn,
                                     input mbrd_pkg::status_e st, input logic [7:0] ln);
    stim_row_t s;
    s = prow(k, d);
    s.typed               = 1'b1;
    s.want.pdu_byte       = pb;
    s.want.pdu_byte_valid = pv;
    s.want.frame_done     = dn;
    s.want.frame_status   = st;
    s.want.pdu_length     = ln;
    return s;
  endfunction

  task automatic clear_frame_state();
    pos_q     = '0;
    total_q   = '0;
    crc_q     = 16'hFFFF;
    fc_q      = '0;
    addr_ok_q = 1'b0;
    crc_lo_q  = '0;
  endtask

  // Advance the predictor by one accepted request and queue the response it owes.
  // Typed rows queue their hand-written response instead; the state still advances.
  task automatic deframe_predict(input logic [7:0] b, input logic rs, input bit typed,
                                 input mbrd_pkg::result_t want);
    mbrd_pkg::result_t r;
    int unsigned       len;
    logic [15:0]       rx_crc;
    r = '0;
    if (rs) begin
      clear_frame_state();
      r.frame_done   = 1'b1;
      r.frame_status = mbrd_pkg::STATUS_ABORTED;
    end else if (pos_q == 0) begin
      addr_ok_q = (b == server_addr_q);
      crc_q     = crc16_next(crc_q, b);
      pos_q     = 9'd1;
    end else if (pos_q == 1) begin
      fc_q             = b;
      crc_q            = crc16_next(crc_q, b);
      pos_q            = 9'd2;
      r.pdu_byte       = b;
      r.pdu_byte_valid = 1'b1;
    end else if (pos_q == 2) begin
      // FIFO responses park the high count byte and resolve the length one byte later.
      len = (fc_q == mbrd_pkg::FcFifo) ? 1 : pdu_len_lookup(fc_q, b);
      if (len == 0 || len > MaxFrameBytes - 3) begin
        clear_frame_state();
        r.frame_done   = 1'b1;
        r.frame_status = mbrd_pkg::STATUS_BAD_LEN;
      end else begin
        if (fc_q == mbrd_pkg::FcFifo) begin
          crc_lo_q = b;
          total_q  = '0;
        end else begin
          total_q = 9'(len + 3);
        end
        crc_q            = crc16_next(crc_q, b);
        pos_q            = 9'd3;
        r.pdu_byte       = b;
        r.pdu_byte_valid = 1'b1;
      end
    end else if (total_q == 0) begin
      len = 3 + {crc_lo_q, b};
      if (len > MaxFrameBytes - 3) begin
        clear_frame_state();
        r.frame_done   = 1'b1;
        r.frame_status = mbrd_pkg::STATUS_BAD_LEN;
      end else begin
        total_q          = 9'(len + 3);
        crc_lo_q         = '0;
        crc_q            = crc16_next(crc_q, b);
        pos_q            = 9'd4;
        r.pdu_byte       = b;
        r.pdu_byte_valid = 1'b1;
      end
    end else if (pos_q + 3 <= total_q) begin
      crc_q            = crc16_next(crc_q, b);
      pos_q            = 9'(pos_q + 1);
      r.pdu_byte       = b;
      r.pdu_byte_valid = 1'b1;
    end else if (pos_q + 2 == total_q) begin
      crc_lo_q = b;
      pos_q    = 9'(pos_q + 1);
    end else begin
      // Address is checked ahead of the CRC.
      rx_crc         = {b, crc_lo_q};
      r.frame_done   = 1'b1;
      r.pdu_length   = 8'(total_q - 3);
      r.frame_status = !addr_ok_q ? mbrd_pkg::STATUS_BAD_ADDR :
                       (rx_crc != crc_q) ? mbrd_pkg::STATUS_BAD_CRC : mbrd_pkg::STATUS_OK;
      clear_frame_state();
    end
    frame_result_q.push_back(typed ? want : r);
    frame_over_q = r.frame_done;
  endtask

  // Offer one request, hold it until accepted, then predict.
  task automatic send_req(input logic [7:0] b, input logic rs, input bit typed,
                          input mbrd_pkg::result_t want);
    if (!quiet_q && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    restart_i  <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    req_cnt++;
    deframe_predict(b, rs, typed, want);
  endtask

  // One response frame with random content. Mostly well formed; some carry a bad
  // CRC, a foreign address, an oversize count or a restart part way through.
  task automatic send_frame();
    logic [7:0] addr, fc, cnt, fifo_hi, fifo_lo, crc_flip, b;
    logic       rs;
    int         abort_at, sent, u;
    addr = ($urandom_range(0, 99) < 90) ? server_addr_q : 8'($urandom_range(0, 255));
    u = $urandom_range(0, 99);
    if (u < 35)      fc = CountedCodes[$urandom_range(0, 8)];
    else if (u < 55) fc = FixedCodes[$urandom_range(0, 5)];
    else if (u < 60) fc = mbrd_pkg::FcReadExcStatus;
    else if (u < 65) fc = mbrd_pkg::FcMaskWrite;
    else if (u < 75) fc = mbrd_pkg::FcExcBit | 8'($urandom_range(0, 127));
    else if (u < 85) fc = mbrd_pkg::FcFifo;
    else             fc = 8'($urandom_range(0, 255));
    // Keep counts small; only a rare frame runs up to the size limit.
    u = $urandom_range(0, 99);
    if (u < 2)       cnt = 8'($urandom_range(248, 255));
    else if (u < 12) cnt = 8'($urandom_range(9, 40));
    else             cnt = 8'($urandom_range(0, 8));
    fifo_hi = ($urandom_range(0, 99) < 90) ? 8'h00 : 8'($urandom_range(0, 255));
    u = $urandom_range(0, 99);
    fifo_lo = (u < 3) ? 8'($urandom_range(245, 255)) : 8'($urandom_range(0, 8));
    crc_flip = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(1, 255)) : 8'h00;
    abort_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 6) : -1;
    // Drop any leftover partial frame first.
    if (pos_q != 0) begin
      send_req(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    end
    frame_over_q = 1'b0;
    sent = 0;
    while (!frame_over_q) begin
      rs = 1'b0;
      if (sent == abort_at) begin
        b  = 8'($urandom_range(0, 255));
        rs = 1'b1;
      end else if (pos_q == 0) begin
        b = addr;
      end else if (pos_q == 1) begin
        b = fc;
      end else if (pos_q == 2) begin
        b = (fc == mbrd_pkg::FcFifo) ? fifo_hi : cnt;
      end else if (total_q == 0) begin
        b = fifo_lo;
      end else if (pos_q + 3 <= total_q) begin
        b = 8'($urandom_range(0, 255));
      end else if (pos_q + 2 == total_q) begin
        b = crc_q[7:0] ^ crc_flip;
      end else begin
        b = crc_q[15:8];
      end
      send_req(b, rs, 1'b0, '0);
      sent++;
    end
  endtask

  task automatic run_traffic(input int n_req);
    int start;
    start = req_cnt;
    while (req_cnt - start < n_req) begin
      if ($urandom_range(0, 99) < 85) begin
        send_frame();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_req(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0, '0);
        end
      end
    end
  endtask

  // Idle the sender until every owed response is out, then write the address.
  task automatic set_server_addr(input logic [7:0] a);
    in_valid_i <= 1'b0;
    while (frame_result_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    server_addr_q  = a;
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("[%0t] response %0d, %s: got %0h, expected %0h", $realtime, rsp_cnt, what,
             got, want);
    err_cnt++;
  endtask

  task automatic check_result();
    mbrd_pkg::result_t want;
    rsp_cnt++;
    if (frame_result_q.size() == 0) begin
      flag_mismatch("response with none pending", 16'({frame_done_o, pdu_byte_o}), 16'h0);
      return;
    end
    want = frame_result_q.pop_front();
    if (pdu_byte_o !== want.pdu_byte)
      flag_mismatch("pdu_byte", 16'(pdu_byte_o), 16'(want.pdu_byte));
    if (pdu_byte_valid_o !== want.pdu_byte_valid)
      flag_mismatch("pdu_byte_valid", 16'(pdu_byte_valid_o), 16'(want.pdu_byte_valid));
    if (frame_done_o !== want.frame_done)
      flag_mismatch("frame_done", 16'(frame_done_o), 16'(want.frame_done));
    if (frame_status_o !== 3'(want.frame_status))
      flag_mismatch("frame_status", 16'(frame_status_o), 16'(3'(want.frame_status)));
    if (pdu_length_o !== want.pdu_length)
      flag_mismatch("pdu_length", 16'(pdu_length_o), 16'(want.pdu_length));
  endtask

  // Receiver: check what drained at this edge, then pick the next ready level.
  // Once, well into the run, hold ready low for a long stretch so the block
  // backs up and drops in_ready while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_result();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_taken && rsp_cnt >= 450) begin
        hold_taken = 1'b1;
        hold_left  = 300;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet_q || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases at several addresses.
  initial begin
    stim_row_t  dir_rows[24];
    logic [7:0] b;
    int         drain_wait;
    server_addr_q = ResetServerAddr;
    clear_frame_state();
    frame_over_q = 1'b0;
    dir_rows = '{
      // restart with no frame in progress
      trow(ROW_RESTART, 8'h00, 8'h00, 1'b0, 1'b1, mbrd_pkg::STATUS_ABORTED, 8'd0),
      // exception response, good CRC
      trow(ROW_DATA, ResetServerAddr, 8'h00, 1'b0, 1'b0, mbrd_pkg::STATUS_OK, 8'd0),
      trow(ROW_DATA, mbrd_pkg::FcExcBit | mbrd_pkg::FcReadHolding,
           mbrd_pkg::FcExcBit | mbrd_pkg::FcReadHolding, 1'b1, 1'b0,
           mbrd_pkg::STATUS_OK, 8'd0),
      trow(ROW_DATA, 8'hFF, 8'hFF, 1'b1, 1'b0, mbrd_pkg::STATUS_OK, 8'd0),
      trow(ROW_CRC_LO, 8'h00, 8'h00, 1'b0, 1'b0, mbrd_pkg::STATUS_OK, 8'd0),
      trow(ROW_CRC_HI, 8'h00, 8'h00, 1'b0, 1'b1, mbrd_pkg::STATUS_OK, 8'd2),
      // unsupported code (MEI) ends the frame on the third byte
      trow(ROW_DATA, ResetServerAddr, 8'h00, 1'b0, 1'b0, mbrd_pkg::STATUS_OK, 8'd0),
      trow(ROW_DATA, FcMei, FcMei, 1'b1, 1'b0, mbrd_pkg::STATUS_OK, 8'd0),
      trow(ROW_DATA, 8'h00, 8'h00, 1'b0, 1'b1, mbrd_pkg::STATUS_BAD_LEN, 8'd0),
      // byte count one past the frame size limit
      prow(ROW_DATA, ResetServerAddr),
      trow(ROW_DATA, mbrd_pkg::FcReadCoils, mbrd_pkg::FcReadCoils, 1'b1, 1'b0,
           mbrd_pkg::STATUS_OK, 8'd0),
      trow(ROW_DATA, 8'hFC, 8'h00, 1'b0, 1'b1, mbrd_pkg::STATUS_BAD_LEN, 8'd0),
      // foreign address together with a broken CRC: address wins
      trow(ROW_DATA, 8'h00, 8'h00, 1'b0, 1'b0, mbrd_pkg::STATUS_OK, 8'd0),
      prow(ROW_DATA, mbrd_pkg::FcReadExcStatus),
      prow(ROW_DATA, 8'h80),
      prow(ROW_DATA, 8'h5A),
      trow(ROW_DATA, 8'hA5, 8'h00, 1'b0, 1'b1, mbrd_pkg::STATUS_BAD_ADDR, 8'd2),
      // FIFO count of 256 only shows up on the fourth byte
      prow(ROW_DATA, ResetServerAddr),
      prow(ROW_DATA, mbrd_pkg::FcFifo),
      prow(ROW_DATA, 8'h01),
      trow(ROW_DATA, 8'h00, 8'h00, 1'b0, 1'b1, mbrd_pkg::STATUS_BAD_LEN, 8'd0),
      // restart in the middle of a frame
      prow(ROW_DATA, ResetServerAddr),
      prow(ROW_DATA, mbrd_pkg::FcWriteRegs),
      trow(ROW_RESTART, 8'hFF, 8'h00, 1'b0, 1'b1, mbrd_pkg::STATUS_ABORTED, 8'd0)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CRC_LO: b = crc_q[7:0];
        ROW_CRC_HI: b = crc_q[15:8];
        default:    b = dir_rows[i].data;
      endcase
      send_req(b, dir_rows[i].kind == ROW_RESTART, dir_rows[i].typed, dir_rows[i].want);
    end

    set_server_addr(8'h00);
    run_traffic(250);
    // Run this phase with both sides always willing; the long receiver hold lands here.
    set_server_addr(8'hFF);
    quiet_q = 1'b1;
    run_traffic(300);
    quiet_q = 1'b0;
    set_server_addr(8'($urandom_range(1, 254)));
    run_traffic(300);
    set_server_addr(ResetServerAddr);
    run_traffic(180);

    // Drain everything owed, then let the pipeline settle.
    in_valid_i <= 1'b0;
    drain_wait = 0;
    while (frame_result_q.size() != 0 && drain_wait < 20000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (8) @(posedge clk_i);
    if (frame_result_q.size() != 0) begin
      flag_mismatch("responses never delivered", 16'(frame_result_q.size()), 16'h0);
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
src/mbrd_pkg.sv
src/mbrd_frame_ctl.sv
src/modbus_rtu_response_deframer_unit.sv
tb/tb_top.sv
